// ----- design/scope_edge_trigger_search_macros.svh -----
// Assertion macros shared by the edge-trigger search modules.
// Included by the controller and the datapath; needs nothing else.
`ifndef SCOPE_EDGE_TRIGGER_SEARCH_MACROS_SVH
`define SCOPE_EDGE_TRIGGER_SEARCH_MACROS_SVH

// same-cycle implication
`define SETRIG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SETRIG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/setrig_pkg.sv -----
// Shared types and constants of the edge-trigger search block.
// Used by the register file, controller, datapath and top level.
package setrig_pkg;

   localparam int SETRIG_RECORD_DEPTH = 4096;
   localparam int FRAC_BITS           = 12;   // fraction bits of the window start
   localparam int OUT_W               = 12;   // start_index / subsample width
   localparam int SAMPLE_W            = 16;
   localparam int LEN_W               = 13;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 16;
   localparam int RSP_DATA_W          = 2 * OUT_W;
   localparam int CNT_W               = $clog2(FRAC_BITS);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRIGGER_LEVEL = 3'd0,
      CSR_HYSTERESIS    = 3'd1,
      CSR_FALLING_EDGE  = 3'd2,
      CSR_RECORD_LENGTH = 3'd3,
      CSR_WINDOW_LENGTH = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [15:0]      trigger_level;   // two's complement Q1.15
      logic [14:0]      hysteresis;
      logic             falling_edge;
      logic [LEN_W-1:0] record_length;
      logic [LEN_W-1:0] window_length;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_DIVIDE,
      ST_PLACE,
      ST_KEEP,
      ST_ADVANCE,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic take;       // request port open
      logic test;       // check the pair, load divider
      logic div_step;   // one quotient bit
      logic place;      // form window start
      logic keep;       // fit check, update best
      logic advance;    // shift sample, bump index
      logic emit;       // load result, clear search
   } dp_cmd_type;

   typedef struct packed {
      logic fired;
      logic rec_end;
      logic out_free;
   } dp_sts_type;

endpackage

// ----- design/setrig_csr.sv -----
// Configuration registers of the edge-trigger search block.
// Depends on setrig_pkg.
module setrig_csr
   import setrig_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_level <= 16'd0;
         cfg_ff.hysteresis    <= 15'd655;
         cfg_ff.falling_edge  <= 1'b0;
         cfg_ff.record_length <= 13'd4096;
         cfg_ff.window_length <= 13'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TRIGGER_LEVEL: cfg_ff.trigger_level <= csr_wdata[15:0];
            CSR_HYSTERESIS:    cfg_ff.hysteresis    <= csr_wdata[14:0];
            CSR_FALLING_EDGE:  cfg_ff.falling_edge  <= csr_wdata[0];
            CSR_RECORD_LENGTH: cfg_ff.record_length <= csr_wdata[LEN_W-1:0];
            CSR_WINDOW_LENGTH: cfg_ff.window_length <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/setrig_ctrl.sv -----
// Sequencer of the edge-trigger search: one request at a time through
// test, divide, place, keep, advance and emit steps. Depends on setrig_pkg.
`include "scope_edge_trigger_search_macros.svh"
module setrig_ctrl
   import setrig_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (req_tvalid) begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            cmd.test = 1'b1;
            cnt_in   = '0;
            state_in = sts.fired ? ST_DIVIDE : ST_ADVANCE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(FRAC_BITS - 1)) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = ST_KEEP;
         end
         ST_KEEP: begin
            cmd.keep = 1'b1;
            state_in = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = sts.rec_end ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            // hold here while the previous result is still unclaimed
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `SETRIG_ASSERT_NOW(a_place_after_div, clock, reset, state_ff == ST_PLACE, ($past(state_ff) == ST_DIVIDE) && ($past(cnt_ff) == CNT_W'(FRAC_BITS - 1)), "place entered without a full divide")
   `SETRIG_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit, sts.out_free, "result loaded over an unclaimed one")
   `SETRIG_ASSERT_NEXT(a_take_to_test, clock, reset, req_tvalid && cmd.take, state_ff == ST_TEST, "accepted request not tested next")

endmodule

// ----- design/setrig_dp.sv -----
// Datapath of the edge-trigger search: hysteresis trigger, restoring
// fraction divider, window placement and result register. Uses setrig_pkg.
`include "scope_edge_trigger_search_macros.svh"
module setrig_dp
   import setrig_pkg::*;
#(
   parameter int RECORD_DEPTH = SETRIG_RECORD_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   input  logic                  req_tvalid,
   input  logic [SAMPLE_W-1:0]   req_sample,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic                  rsp_found,
   output logic [OUT_W-1:0]      rsp_start_index,
   output logic [OUT_W-1:0]      rsp_subsample
);

   localparam logic [LEN_W-1:0] DEPTH_CAP =
      (RECORD_DEPTH > (2**LEN_W - 1)) ? LEN_W'(2**LEN_W - 1) : LEN_W'(RECORD_DEPTH);
   localparam int POS_W = LEN_W + FRAC_BITS + 3;
   localparam int FR_W  = FRAC_BITS + 1;

   // search state
   logic [SAMPLE_W-1:0] prev_ff, cur_ff;
   logic                armed_ff;
   logic [LEN_W-1:0]    index_ff;
   logic                have_ff;
   logic [OUT_W-1:0]    kept_start_ff, kept_frac_ff;

   // divider
   logic [17:0]          rem_ff;
   logic [16:0]          den_ff;
   logic [FRAC_BITS-1:0] quo_ff;
   logic                 spec_ff, spec_one_ff;

   logic signed [POS_W-1:0] pos_ff;

   // result register
   logic             rsp_valid_ff, found_ff;
   logic [OUT_W-1:0] start_ff, sub_ff;

   logic [LEN_W-1:0]   total;
   logic signed [17:0] level_x, hyst_x, low_x, high_x, prev_x, cur_x, num_x, den_x;
   logic [16:0]        num_mag, den_mag;
   logic               pair_ok, arm_set, hit, arm_next, spec_zero, spec_one;
   logic [17:0]        rem_sh;
   logic               rem_ge;
   logic [FR_W-1:0]    frac;
   logic signed [POS_W-1:0] pos_new, win_full, end_x, limit_x;
   logic               fits;
   logic [LEN_W-1:0]   index_next;
   logic               result_ok;

   assign total = (cfg.record_length > DEPTH_CAP) ? DEPTH_CAP : cfg.record_length;

   assign level_x = {{2{cfg.trigger_level[15]}}, cfg.trigger_level};
   assign hyst_x  = {3'b000, cfg.hysteresis};
   assign low_x   = level_x - hyst_x;
   assign high_x  = level_x + hyst_x;
   assign prev_x  = {{2{prev_ff[SAMPLE_W-1]}}, prev_ff};
   assign cur_x   = {{2{cur_ff[SAMPLE_W-1]}}, cur_ff};
   assign num_x   = level_x - prev_x;
   assign den_x   = cur_x - prev_x;
   assign num_mag = num_x[17] ? 17'(-num_x) : num_x[16:0];
   assign den_mag = den_x[17] ? 17'(-den_x) : den_x[16:0];

   assign pair_ok = (index_ff != '0);

   always_comb begin
      if (cfg.falling_edge) begin
         arm_set = (prev_x > high_x);
         hit     = (cur_x <= low_x);
      end else begin
         arm_set = (prev_x < low_x);
         hit     = (cur_x >= high_x);
      end
   end

   assign arm_next  = armed_ff | arm_set;
   assign sts.fired = pair_ok & arm_next & hit;

   // level at or behind prev or flat pair -> 0, level at or past curr -> 1
   assign spec_zero = (den_x == '0) || (num_x == '0) || (num_x[17] != den_x[17]);
   assign spec_one  = !spec_zero && (num_mag >= den_mag);

   assign rem_sh = {rem_ff[16:0], 1'b0};
   assign rem_ge = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      if (spec_ff) begin
         frac = spec_one_ff ? FR_W'(2**FRAC_BITS) : '0;
      end else begin
         frac = {1'b0, quo_ff};
      end
   end

   // start = (i - 1) + fraction - window / 2, in units of 2^-FRAC_BITS
   assign pos_new = signed'({3'b000, index_ff - 1'b1, {FRAC_BITS{1'b0}}})
                  + signed'(POS_W'(frac))
                  - signed'({4'b0000, cfg.window_length, {(FRAC_BITS-1){1'b0}}});
   assign win_full = signed'({3'b000, cfg.window_length, {FRAC_BITS{1'b0}}});
   assign limit_x  = signed'({3'b000, total, {FRAC_BITS{1'b0}}});
   assign end_x    = pos_ff + win_full;
   assign fits     = !pos_ff[POS_W-1] && (end_x <= limit_x);

   assign index_next  = index_ff + 1'b1;
   assign sts.rec_end = (index_next >= total);
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   assign result_ok = have_ff && (cfg.window_length >= LEN_W'(2))
                   && ({1'b0, total} >= ({1'b0, cfg.window_length} + (LEN_W+1)'(2)));

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= '0;
         armed_ff      <= 1'b0;
         index_ff      <= '0;
         have_ff       <= 1'b0;
         kept_start_ff <= '0;
         kept_frac_ff  <= '0;
      end else begin
         if (cmd.test && pair_ok) begin
            armed_ff <= arm_next & ~hit;
         end
         if (cmd.keep && fits) begin
            have_ff       <= 1'b1;
            kept_start_ff <= pos_ff[FRAC_BITS +: OUT_W];
            kept_frac_ff  <= OUT_W'(pos_ff[FRAC_BITS-1:0]);
         end
         if (cmd.advance) begin
            prev_ff  <= cur_ff;
            index_ff <= index_next;
         end
         if (cmd.emit) begin
            prev_ff       <= '0;
            armed_ff      <= 1'b0;
            index_ff      <= '0;
            have_ff       <= 1'b0;
            kept_start_ff <= '0;
            kept_frac_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && cmd.take) begin
         cur_ff <= req_sample;
      end
      if (cmd.test) begin
         rem_ff      <= {1'b0, num_mag};
         den_ff      <= den_mag;
         quo_ff      <= '0;
         spec_ff     <= spec_zero | spec_one;
         spec_one_ff <= spec_one;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         quo_ff <= {quo_ff[FRAC_BITS-2:0], rem_ge};
      end
      if (cmd.place) begin
         pos_ff <= pos_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         found_ff <= result_ok;
         start_ff <= result_ok ? kept_start_ff : '0;
         sub_ff   <= result_ok ? kept_frac_ff : '0;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_start_index = start_ff;
   assign rsp_subsample   = sub_ff;

   `SETRIG_ASSERT_NEXT(a_emit_clears, clock, reset, cmd.emit, (index_ff == '0) && !have_ff && !armed_ff, "search not cleared after result")
   `SETRIG_ASSERT_NEXT(a_keep_sets_have, clock, reset, cmd.keep && fits, have_ff, "fitting start not recorded")
   `SETRIG_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid_ff && !found_ff, (start_ff == '0) && (sub_ff == '0), "empty result carries a nonzero start")

endmodule

// ----- design/scope_edge_trigger_search.sv -----
// Edge-trigger search with hysteresis over one record of Q1.15 samples.
//
// req_ channel: one sample per request, oldest first (req_tdata[15:0]).
// rsp_ channel: one result at the end of each record: found on rsp_tuser,
// the integer window start and its Q0.12 fraction on rsp_tdata. csr_ port:
// write enable, register index and data; writes land at the clock edge.
// The user must write only while idle; the block does not enforce it.
//
// Each request passes accept, trigger test and advance. A request that
// fires the trigger also passes the restoring divider that forms the
// crossing fraction, one bit a cycle, then the place and keep steps
// that place and check the window. The request that ends a record also
// loads the result register, which raises rsp_tvalid.
// A result waits in the output register; the next samples are taken
// meanwhile, and only a record end stalls until the waiting result leaves.
// Reset (synchronous) restores the register defaults, empties the result
// register and starts a fresh record.
module scope_edge_trigger_search
   import setrig_pkg::*;
#(
   parameter int RECORD_DEPTH = SETRIG_RECORD_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_W-1:0]    req_tdata,   // [15:0] sample
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [11:0] start_index, [23:12] subsample
   output logic                   rsp_tuser,   // [0] found
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type          cfg;
   dp_cmd_type       cmd;
   dp_sts_type       sts;
   logic             found;
   logic [OUT_W-1:0] start_index, subsample;

   setrig_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   setrig_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .sts        (sts),
      .cmd        (cmd)
   );

   setrig_dp #(
      .RECORD_DEPTH (RECORD_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .sts             (sts),
      .req_tvalid      (req_tvalid),
      .req_sample      (req_tdata),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_found       (found),
      .rsp_start_index (start_index),
      .rsp_subsample   (subsample)
   );

   assign req_tready = cmd.take;
   assign rsp_tdata  = {subsample, start_index};
   assign rsp_tuser  = found;

endmodule

// ----- tb/sv/trigger_search_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the edge-trigger search: mirrors the register writes, predicts
// the end-of-record result from every accepted request and compares rsp_ beats.
// Depends on setrig_pkg for widths and register indexes.
module trigger_search_checker
   import setrig_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [SAMPLE_W-1:0]    req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   rsp_tuser,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     error_count,
   output int                     pending_count,
   output int                     record_count,
   output int                     trigger_count
);

   localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;

   typedef struct packed {
      logic             found;
      logic [OUT_W-1:0] start_index;
      logic [OUT_W-1:0] subsample;
   } window_report_type;

   window_report_type window_reports[$];

   // register mirror
   logic signed [15:0] level;
   logic [14:0]        band;
   logic               falling;
   logic [LEN_W-1:0]   rec_len;
   logic [LEN_W-1:0]   win_len;

   // search state
   logic signed [SAMPLE_W-1:0] last_sample;
   logic                       armed;
   logic [LEN_W-1:0]           sample_count;
   logic                       have_start;
   logic [OUT_W-1:0]           kept_start;
   logic [OUT_W-1:0]           kept_frac;

   task automatic clear_search();
      last_sample  = '0;
      armed        = 1'b0;
      sample_count = '0;
      have_start   = 1'b0;
      kept_start   = '0;
      kept_frac    = '0;
   endtask

   // (level - prev) / (curr - prev), truncated, clamped to 0..1 in Q0.12
   function automatic longint edge_fraction(longint prev, longint curr);
      longint num, den;
      num = longint'(level) - prev;
      den = curr - prev;
      if (den == 0 || num == 0) return 0;
      if ((num < 0) != (den < 0)) return 0;
      if (num < 0) begin
         num = -num;
         den = -den;
      end
      if (num >= den) return FRAC_ONE;
      return (num * FRAC_ONE) / den;
   endfunction

   task automatic test_pair(longint prev, longint curr, longint idx, longint total);
      longint lo, hi, pos;
      logic   fired;
      lo    = longint'(level) - longint'(band);
      hi    = longint'(level) + longint'(band);
      fired = 1'b0;
      if (!falling) begin
         if (prev < lo) armed = 1'b1;
         if (armed && curr >= hi) fired = 1'b1;
      end else begin
         if (prev > hi) armed = 1'b1;
         if (armed && curr <= lo) fired = 1'b1;
      end
      if (fired) begin
         armed = 1'b0;
         pos = (idx - 1) * FRAC_ONE + edge_fraction(prev, curr)
               - longint'(win_len) * (FRAC_ONE / 2);
         // keep the latest start whose window fits in the record
         if (pos >= 0 && pos + longint'(win_len) * FRAC_ONE <= total * FRAC_ONE) begin
            have_start = 1'b1;
            kept_start = pos[FRAC_BITS +: OUT_W];
            kept_frac  = OUT_W'(pos[FRAC_BITS-1:0]);
         end
      end
   endtask

   task automatic search_sample(logic [SAMPLE_W-1:0] data);
      longint            s, total;
      window_report_type rep;
      s     = longint'($signed(data));
      total = (rec_len > SETRIG_RECORD_DEPTH) ? SETRIG_RECORD_DEPTH : rec_len;
      if (sample_count >= 1) test_pair(longint'(last_sample), s, sample_count, total);
      last_sample  = data;
      sample_count = sample_count + 1'b1;
      if (sample_count >= total) begin
         rep.found       = have_start && win_len >= 2 && total >= longint'(win_len) + 2;
         rep.start_index = rep.found ? kept_start : '0;
         rep.subsample   = rep.found ? kept_frac : '0;
         window_reports.push_back(rep);
         clear_search();
      end
   endtask

   task automatic apply_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      unique case (idx)
         CSR_TRIGGER_LEVEL: level   = data;
         CSR_HYSTERESIS:    band    = data[14:0];
         CSR_FALLING_EDGE:  falling = data[0];
         CSR_RECORD_LENGTH: rec_len = data[LEN_W-1:0];
         CSR_WINDOW_LENGTH: win_len = data[LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic note_error(string msg);
      error_count++;
      if (error_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_report(logic [RSP_DATA_W-1:0] beat, logic flag);
      window_report_type want;
      logic [OUT_W-1:0]  got_start, got_sub;
      got_start = beat[OUT_W-1:0];
      got_sub   = beat[2*OUT_W-1:OUT_W];
      if (window_reports.size() == 0) begin
         note_error($sformatf("result %h/%b arrived with no record pending", beat, flag));
         return;
      end
      want = window_reports.pop_front();
      record_count++;
      if (want.found) trigger_count++;
      if (flag !== want.found || got_start !== want.start_index ||
          got_sub !== want.subsample)
         note_error($sformatf({"record %0d: expected found %0b start %0d sub %0d, ",
                               "got found %0b start %0d sub %0d"},
                              record_count, want.found, want.start_index, want.subsample,
                              flag, got_start, got_sub));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         level   = '0;
         band    = 15'd655;
         falling = 1'b0;
         rec_len = 13'd4096;
         win_len = 13'd64;
         clear_search();
         window_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_report(rsp_tdata, rsp_tuser);
         if (csr_we) apply_write(csr_index, csr_wdata);
         if (req_tvalid && req_tready) search_sample(req_tdata);
      end
      pending_count = window_reports.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Top of the edge-trigger search testbench: clock, reset, request and result
// drivers and register writes. Needs setrig_pkg, scope_edge_trigger_search
// and trigger_search_checker.
module testbench;
   import setrig_pkg::*;

   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int CYCLE_LIMIT    = 3000000;
   localparam int RANDOM_SAMPLES = 580;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int error_count, pending_count, record_count, trigger_count;
   int hold_len     = 0;   // long receiver hold-off, picked up by the receiver
   bit steady       = 0;   // no idling on either side
   int sample_total = 0;
   int write_total  = 0;
   int cycle_count  = 0;

   scope_edge_trigger_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   trigger_search_checker results_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .record_count  (record_count),
      .trigger_count (trigger_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result side
   initial begin : receiver
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_len > 0) begin
            gap      = hold_len;
            hold_len = 0;
         end else begin
            gap = idle_gap();
         end
         if (gap == 0) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   initial begin
      @(posedge clock);
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d records still pending", cycle_count,
               pending_count);
      $display("FAILED: results differ");
      $finish;
   end

   task automatic send_sample(int value);
      int                  gap;
      logic [SAMPLE_W-1:0] word;
      if (value > 32767) value = 32767;
      else if (value < -32768) value = -32768;
      word = value[SAMPLE_W-1:0];
      gap  = idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      sample_total++;
   endtask

   task automatic write_reg(csr_index_type idx, int value);
      logic [CSR_DATA_W-1:0] data;
      data = value[CSR_DATA_W-1:0];
      // junk above the register width must be dropped by the block
      case (idx)
         CSR_HYSTERESIS:                      data[15]    = 1'($urandom_range(0, 1));
         CSR_FALLING_EDGE:                    data[15:1]  = 15'($urandom);
         CSR_RECORD_LENGTH, CSR_WINDOW_LENGTH: data[15:13] = 3'($urandom);
         default: ;
      endcase
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      write_total++;
   endtask

   task automatic configure(int lvl, int hyst, bit fall, int rec, int win);
      write_reg(CSR_TRIGGER_LEVEL, lvl);
      write_reg(CSR_HYSTERESIS, hyst);
      write_reg(CSR_FALLING_EDGE, fall);
      write_reg(CSR_RECORD_LENGTH, rec);
      write_reg(CSR_WINDOW_LENGTH, win);
   endtask

   // drop valid, wait for every pending result, then let the block finish
   // a sample that produces no result
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // square / ramp-ish wave around the level, swinging past the band, with noise
   task automatic send_wave(int count, int center, int floor_amp);
      int dir, run, amp, v;
      dir = 1;
      run = 0;
      amp = floor_amp + 1;
      for (int n = 0; n < count; n++) begin
         if (run == 0) begin
            dir = -dir;
            run = $urandom_range(1, 6);
            amp = floor_amp + int'($urandom_range(1, 3000));
         end
         run--;
         case ($urandom_range(0, 9))
            0:       v = int'($urandom_range(0, 65535)) - 32768;
            1, 2, 3: v = center + dir * int'($urandom_range(0, amp));
            default: v = center + dir * amp + int'($urandom_range(0, 200)) - 100;
         endcase
         send_sample(v);
      end
   endtask

   task automatic random_phase();
      int lvl, hyst, rec, win, count, r;
      bit fall;
      r = $urandom_range(0, 9);
      if (r == 0) lvl = $urandom_range(0, 1) ? 32767 : -32768;
      else lvl = int'($urandom_range(0, 40000)) - 20000;
      r = $urandom_range(0, 99);
      if (r < 10) hyst = 0;
      else if (r < 15) hyst = 32767;
      else if (r < 20) hyst = $urandom_range(0, 32767);
      else hyst = $urandom_range(0, 2000);
      fall = $urandom_range(0, 1);
      rec  = ($urandom_range(0, 99) < 5) ? $urandom_range(0, 1) : $urandom_range(6, 48);
      r = $urandom_range(0, 99);
      if (r < 8) win = $urandom_range(0, 1);
      else if (r < 14) win = rec - 1 + int'($urandom_range(0, 4));
      else if (r < 17) win = $urandom_range(0, 1) ? 4096 : 8191;
      else if (rec >= 4) win = $urandom_range(2, rec - 2);
      else win = 2;
      if (win < 0) win = 0;
      configure(lvl, hyst, fall, rec, win);
      if (rec < 2) begin
         count = $urandom_range(2, 6);
      end else begin
         count = rec * int'($urandom_range(1, 3));
         // sometimes stop mid-record; the next setting then applies to it
         if ($urandom_range(0, 99) < 30) count += $urandom_range(1, rec - 1);
      end
      send_wave(count, lvl, hyst);
      settle();
   endtask

   initial begin
      int sample_base;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_TRIGGER_LEVEL;
      csr_wdata  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full-scale swings, exact fraction one half
      configure(0, 0, 0, 4, 2);
      send_sample(-32768);
      send_sample(32767);
      send_sample(-32768);
      send_sample(32767);
      settle();

      // arming below the band, then a level change mid-record that
      // fires on equal neighbours
      configure(0, 10, 0, 6, 2);
      send_sample(-20);
      send_sample(5);
      settle();
      write_reg(CSR_TRIGGER_LEVEL, -10);
      write_reg(CSR_HYSTERESIS, 0);
      send_sample(5);
      send_sample(5);
      send_sample(30);
      send_sample(40);
      settle();

      // empty record: a result after every request
      configure(32767, 32767, 1, 0, 2);
      send_sample(32767);
      send_sample(-32768);
      send_sample(0);
      settle();

      // single-sample record
      configure(-32768, 0, 1, 1, 0);
      send_sample(100);
      send_sample(-32768);
      settle();

      // falling edges onto the most negative level
      configure(-32768, 0, 1, 5, 2);
      send_sample(100);
      send_sample(-32768);
      send_sample(200);
      send_sample(-32768);
      send_sample(-32768);
      settle();

      // record length cut below the count already taken
      configure(0, 0, 0, 20, 4);
      for (int n = 0; n < 5; n++) send_sample((n % 2) ? 1000 : -1000);
      settle();
      write_reg(CSR_RECORD_LENGTH, 4);
      send_sample(1000);
      settle();

      // receiver holds off while the sender keeps offering
      steady = 1;
      configure(0, 100, 0, 4, 2);
      hold_len = HOLD_CYCLES;
      send_wave(40, 0, 100);
      settle();
      steady = 0;

      sample_base = sample_total;
      while (sample_total - sample_base < RANDOM_SAMPLES)
         random_phase();

      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d samples over %0d register writes; %0d records checked.",
               sample_total, write_total, record_count);
      $display("%0d records reported a trigger; both edges, empty records and a long stall ran.",
               trigger_count);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
